FILE: hw/rtl/gpps_pkg.sv
// ----------------------------------------------------------------------------
// gpps_pkg - Goldbach prime pair search shared definitions
// Field widths, datapath operation codes, result codes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gpps_pkg;

   localparam int PRIME_LIMIT_DEF = 16384;
   localparam int TABLE_DEPTH_DEF = 2048;

   localparam int NUM_W    = 15;
   localparam int PRIME_W  = 14;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND   = 2'd0,
      ST_INVALID = 2'd1,
      ST_MISSING = 2'd2
   } rsp_status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_SIEVE_RD_I,
      OP_MARK_INIT,
      OP_MARK,
      OP_NEXT_I,
      OP_COL_INIT,
      OP_SIEVE_RD_A,
      OP_COL_STEP,
      OP_LOAD,
      OP_BS_RD,
      OP_BS_UPD,
      OP_LO_RD,
      OP_LO_FIRST,
      OP_LO_CAP,
      OP_HI_CAP,
      OP_LO_DEC,
      OP_HI_INC,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type      op;
      rsp_status_type res;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic outer_more;
      logic sieve_bit;
      logic mark_last;
      logic col_last;
      logic num_bad;
      logic bs_done;
      logic ub_zero;
      logic ub_end;
      logic lo_eq_half;
      logic sum_eq;
      logic sum_gt;
      logic lo_zero;
      logic hi_end;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/gpps_datapath.sv
// ----------------------------------------------------------------------------
// gpps_datapath - sieve, prime table and pointer datapath
// Holds the sieve bit memory, the prime table memory, the build counters,
// the binary search bounds, the two walk pointers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpps_datapath
   import gpps_pkg::*;
#(
   parameter int PRIME_LIMIT = PRIME_LIMIT_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output      dp_stat_type         stat,
   input  wire logic [NUM_W-1:0]    number_in,
   output      logic [STATUS_W-1:0] status,
   output      logic [PRIME_W-1:0]  small_prime,
   output      logic [PRIME_W-1:0]  large_prime
);

   localparam int SW   = $clog2(PRIME_LIMIT);
   localparam int IW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (SW + 1 > NUM_W) ? SW + 1 : NUM_W;

   localparam logic [2*SW:0] LIMIT_SQ   = (2*SW+1)'(PRIME_LIMIT);
   localparam logic [SW+1:0] LIMIT_J    = (SW+2)'(PRIME_LIMIT);
   localparam logic [SW-1:0] LAST_CAND  = SW'(PRIME_LIMIT - 1);
   localparam logic [CW-1:0] DEPTH_LAST = CW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C    = CW'(TABLE_DEPTH);

   logic          sieve_mem_ff [PRIME_LIMIT];
   logic [SW-1:0] table_mem_ff [TABLE_DEPTH];

   logic [SW-1:0]       a_ff, a_in;
   logic [SW-1:0]       i_ff, i_in;
   logic [SW:0]         j_ff, j_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [NUM_W-1:0]    n_ff, n_in;
   logic [CW-1:0]       lob_ff, lob_in;
   logic [CW-1:0]       hib_ff, hib_in;
   logic [IW-1:0]       mid_ff, mid_in;
   logic [IW-1:0]       lo_ff, lo_in;
   logic [IW-1:0]       hi_ff, hi_in;
   logic [SW-1:0]       lo_val_ff, lo_val_in;
   logic [SW-1:0]       hi_val_ff, hi_val_in;
   logic                sieve_q_ff;
   logic [SW-1:0]       tbl_q_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PRIME_W-1:0]  small_ff, small_in;
   logic [PRIME_W-1:0]  large_ff, large_in;

   logic          sv_we, sv_wdata, sv_re;
   logic [SW-1:0] sv_waddr, sv_raddr;
   logic          tb_we, tb_re;
   logic [IW-1:0] tb_waddr, tb_raddr;

   logic [2*SW-1:0]      i_sq;
   logic [SW+1:0]        j_next;
   logic [PRIME_W-1:0]   half;
   logic [CMPW-1:0]      sum;
   logic [CMPW-1:0]      n_cmp;
   logic [CMPW-1:0]      half_cmp;
   logic [CMPW-1:0]      tbl_cmp;
   logic [CW:0]          mid_sum;
   logic [IW-1:0]        mid;
   logic [CW-1:0]        ub_m1;
   logic [CW:0]          hi_nxt;
   logic [SW+PRIME_W-1:0] small_wide;
   logic [SW+PRIME_W-1:0] large_wide;

   always_comb begin
      i_sq       = i_ff * i_ff;
      j_next     = (SW+2)'(j_ff) + (SW+2)'(i_ff);
      half       = n_ff[NUM_W-1:1];
      sum        = CMPW'(lo_val_ff) + CMPW'(hi_val_ff);
      n_cmp      = CMPW'(n_ff);
      half_cmp   = CMPW'(half);
      tbl_cmp    = CMPW'(tbl_q_ff);
      mid_sum    = ((CW+1)'(lob_ff) + (CW+1)'(hib_ff)) >> 1;
      mid        = mid_sum[IW-1:0];
      ub_m1      = lob_ff - 1'b1;
      hi_nxt     = (CW+1)'(hi_ff) + 1'b1;
      small_wide = (SW+PRIME_W)'(lo_val_ff);
      large_wide = (SW+PRIME_W)'(hi_val_ff);
   end

   always_comb begin
      stat.clear_last = (a_ff == LAST_CAND);
      stat.outer_more = ({1'b0, i_sq} < LIMIT_SQ);
      stat.sieve_bit  = sieve_q_ff;
      stat.mark_last  = (j_next >= LIMIT_J);
      stat.col_last   = (a_ff == LAST_CAND) || (!sieve_q_ff && (count_ff == DEPTH_LAST));
      stat.num_bad    = (n_ff <= NUM_W'(2)) || n_ff[0];
      stat.bs_done    = (lob_ff == hib_ff);
      stat.ub_zero    = (lob_ff == '0);
      stat.ub_end     = (lob_ff == count_ff);
      stat.lo_eq_half = (tbl_cmp == half_cmp);
      stat.sum_eq     = (sum == n_cmp);
      stat.sum_gt     = (sum > n_cmp);
      stat.lo_zero    = (lo_ff == '0);
      stat.hi_end     = (hi_nxt >= (CW+1)'(count_ff));
   end

   always_comb begin
      a_in      = a_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      lob_in    = lob_ff;
      hib_in    = hib_ff;
      mid_in    = mid_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      lo_val_in = lo_val_ff;
      hi_val_in = hi_val_ff;
      status_in = status_ff;
      small_in  = small_ff;
      large_in  = large_ff;
      sv_we     = 1'b0;
      sv_wdata  = 1'b0;
      sv_waddr  = a_ff;
      sv_re     = 1'b0;
      sv_raddr  = a_ff;
      tb_we     = 1'b0;
      tb_waddr  = count_ff[IW-1:0];
      tb_re     = 1'b0;
      tb_raddr  = mid;
      case (cmd.op)
         OP_NONE: begin
         end
         OP_CLEAR: begin
            sv_we = 1'b1;
            a_in  = a_ff + 1'b1;
         end
         OP_SIEVE_RD_I: begin
            sv_re    = 1'b1;
            sv_raddr = i_ff;
         end
         OP_MARK_INIT: begin
            j_in = i_sq[SW:0];
         end
         OP_MARK: begin
            sv_we    = 1'b1;
            sv_wdata = 1'b1;
            sv_waddr = j_ff[SW-1:0];
            j_in     = j_next[SW:0];
         end
         OP_NEXT_I: begin
            i_in = i_ff + 1'b1;
         end
         OP_COL_INIT: begin
            a_in     = SW'(2);
            count_in = '0;
         end
         OP_SIEVE_RD_A: begin
            sv_re = 1'b1;
         end
         OP_COL_STEP: begin
            if (!sieve_q_ff) begin
               tb_we    = 1'b1;
               count_in = count_ff + 1'b1;
            end
            a_in = a_ff + 1'b1;
         end
         OP_LOAD: begin
            n_in   = number_in;
            lob_in = '0;
            hib_in = count_ff;
         end
         OP_BS_RD: begin
            tb_re  = 1'b1;
            mid_in = mid;
         end
         OP_BS_UPD: begin
            if (tbl_cmp <= half_cmp) begin
               lob_in = CW'(mid_ff) + 1'b1;
            end else begin
               hib_in = CW'(mid_ff);
            end
         end
         OP_LO_RD: begin
            tb_re    = 1'b1;
            tb_raddr = ub_m1[IW-1:0];
            lo_in    = ub_m1[IW-1:0];
         end
         OP_LO_FIRST: begin
            lo_val_in = tbl_q_ff;
            tb_re     = 1'b1;
            tb_raddr  = lob_ff[IW-1:0];
            if (tbl_cmp == half_cmp) begin
               hi_in     = lo_ff;
               hi_val_in = tbl_q_ff;
            end else begin
               hi_in = lob_ff[IW-1:0];
            end
         end
         OP_LO_CAP: begin
            lo_val_in = tbl_q_ff;
         end
         OP_HI_CAP: begin
            hi_val_in = tbl_q_ff;
         end
         OP_LO_DEC: begin
            lo_in    = lo_ff - 1'b1;
            tb_re    = 1'b1;
            tb_raddr = lo_ff - 1'b1;
         end
         OP_HI_INC: begin
            hi_in    = hi_nxt[IW-1:0];
            tb_re    = 1'b1;
            tb_raddr = hi_nxt[IW-1:0];
         end
         OP_EMIT: begin
            status_in = cmd.res;
            if (cmd.res == ST_FOUND) begin
               small_in = small_wide[PRIME_W-1:0];
               large_in = large_wide[PRIME_W-1:0];
            end else begin
               small_in = '0;
               large_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sv_we) begin
         sieve_mem_ff[sv_waddr] <= sv_wdata;
      end
      if (sv_re) begin
         sieve_q_ff <= sieve_mem_ff[sv_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tb_we) begin
         table_mem_ff[tb_waddr] <= a_ff;
      end
      if (tb_re) begin
         tbl_q_ff <= table_mem_ff[tb_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff     <= '0;
         i_ff     <= SW'(2);
         count_ff <= '0;
      end else begin
         a_ff     <= a_in;
         i_ff     <= i_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      n_ff      <= n_in;
      lob_ff    <= lob_in;
      hib_ff    <= hib_in;
      mid_ff    <= mid_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      lo_val_ff <= lo_val_in;
      hi_val_ff <= hi_val_in;
      status_ff <= status_in;
      small_ff  <= small_in;
      large_ff  <= large_in;
   end

   assign status      = status_ff;
   assign small_prime = small_ff;
   assign large_prime = large_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("prime count past table depth");

   a_bs_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_BS_RD |-> lob_ff < hib_ff)
      else $error("binary search probe on empty range");

   a_ptr_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LO_DEC || cmd.op == OP_HI_INC) |-> lo_ff <= hi_ff)
      else $error("walk pointers crossed");

   a_found_sum: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT && cmd.res == ST_FOUND) |-> sum == n_cmp)
      else $error("pair reported with wrong sum");

endmodule

`default_nettype wire

FILE: hw/rtl/gpps_ctrl.sv
// ----------------------------------------------------------------------------
// gpps_ctrl - Goldbach prime pair search controller
// Sequences the sieve build, the table collect, the per-query binary search
// and the two-pointer walk, and owns the handshakes and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gpps_ctrl
   import gpps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      dp_cmd_type  cmd,
   input  wire dp_stat_type stat
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_OUTER_RD,
      S_OUTER_CHK,
      S_MARK,
      S_MARK_DONE,
      S_COL_RD,
      S_COL_CHK,
      S_IDLE,
      S_CHECK,
      S_BS_RD,
      S_BS_CHK,
      S_START,
      S_LO_CHK,
      S_HI_CAP,
      S_LO_CAP,
      S_WALK,
      S_FINISH
   } state_type;

   state_type      state_ff, state_in;
   rsp_status_type res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = OP_NONE;
      cmd.res      = res_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_last) begin
               state_in = S_OUTER_RD;
            end
         end
         S_OUTER_RD: begin
            if (stat.outer_more) begin
               cmd.op   = OP_SIEVE_RD_I;
               state_in = S_OUTER_CHK;
            end else begin
               cmd.op   = OP_COL_INIT;
               state_in = S_COL_RD;
            end
         end
         S_OUTER_CHK: begin
            if (stat.sieve_bit) begin
               cmd.op   = OP_NEXT_I;
               state_in = S_OUTER_RD;
            end else begin
               cmd.op   = OP_MARK_INIT;
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            cmd.op = OP_MARK;
            if (stat.mark_last) begin
               state_in = S_MARK_DONE;
            end
         end
         S_MARK_DONE: begin
            cmd.op   = OP_NEXT_I;
            state_in = S_OUTER_RD;
         end
         S_COL_RD: begin
            cmd.op   = OP_SIEVE_RD_A;
            state_in = S_COL_CHK;
         end
         S_COL_CHK: begin
            cmd.op   = OP_COL_STEP;
            state_in = stat.col_last ? S_IDLE : S_COL_RD;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.num_bad) begin
               res_in   = ST_INVALID;
               state_in = S_FINISH;
            end else begin
               state_in = S_BS_RD;
            end
         end
         S_BS_RD: begin
            if (stat.bs_done) begin
               state_in = S_START;
            end else begin
               cmd.op   = OP_BS_RD;
               state_in = S_BS_CHK;
            end
         end
         S_BS_CHK: begin
            cmd.op   = OP_BS_UPD;
            state_in = S_BS_RD;
         end
         S_START: begin
            if (stat.ub_zero) begin
               res_in   = ST_MISSING;
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_LO_RD;
               state_in = S_LO_CHK;
            end
         end
         S_LO_CHK: begin
            if (stat.lo_eq_half) begin
               cmd.op   = OP_LO_FIRST;
               state_in = S_WALK;
            end else if (stat.ub_end) begin
               res_in   = ST_MISSING;
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_LO_FIRST;
               state_in = S_HI_CAP;
            end
         end
         S_HI_CAP: begin
            cmd.op   = OP_HI_CAP;
            state_in = S_WALK;
         end
         S_LO_CAP: begin
            cmd.op   = OP_LO_CAP;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (stat.sum_eq) begin
               res_in   = ST_FOUND;
               state_in = S_FINISH;
            end else if (stat.sum_gt) begin
               if (stat.lo_zero) begin
                  res_in   = ST_MISSING;
                  state_in = S_FINISH;
               end else begin
                  cmd.op   = OP_LO_DEC;
                  state_in = S_LO_CAP;
               end
            end else begin
               if (stat.hi_end) begin
                  res_in   = ST_MISSING;
                  state_in = S_FINISH;
               end else begin
                  cmd.op   = OP_HI_INC;
                  state_in = S_HI_CAP;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         res_ff       <= ST_FOUND;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/goldbach_prime_pair_search_unit.sv
// ----------------------------------------------------------------------------
// goldbach_prime_pair_search_unit - Goldbach prime pair search, top level
// Splits an even number into two primes with a two-pointer walk over a
// prime table that a sieve builds after reset.
// ----------------------------------------------------------------------------
// After reset the unit runs a sieve of PRIME_LIMIT bits and collects the
// primes into a TABLE_DEPTH-entry table; req_tready stays low meanwhile.
// Each query then takes one beat in and gives one beat out. An odd number
// or one of 2 or less is answered as invalid without a search. An even
// number takes a binary search over the table, seats both pointers, then
// walks them outward one step at a time; the pace of the search and of
// the walk is set by the single read port of the table memory with its
// registered output. The next request is taken while a finished result
// still waits on the rsp side.
// ----------------------------------------------------------------------------
`default_nettype none

module goldbach_prime_pair_search_unit
   import gpps_pkg::*;
#(
   parameter int PRIME_LIMIT = PRIME_LIMIT_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // number_in[14:0], zero pad
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata    // status[1:0], small_prime[15:2],
                                         // large_prime[29:16], zero pad
);

   dp_cmd_type          cmd;
   dp_stat_type         stat;
   logic [STATUS_W-1:0] status;
   logic [PRIME_W-1:0]  small_prime;
   logic [PRIME_W-1:0]  large_prime;

   gpps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   gpps_datapath #(
      .PRIME_LIMIT (PRIME_LIMIT),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .number_in   (req_tdata[NUM_W-1:0]),
      .status      (status),
      .small_prime (small_prime),
      .large_prime (large_prime)
   );

   assign rsp_tdata = {2'b00, large_prime, small_prime, status};

endmodule

`default_nettype wire
